// File: rtl/core/preemptive_priority_scheduler_macros.svh
// Assertion macros for the preemptive priority scheduler checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Same-cycle implication, held off while reset is active.
`define PPSCH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is active.
`define PPSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ppsch_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
// No dependencies; used by the top level and its checker.
package ppsch_pkg;

	// Width of the process count register and of the completion counter.
	localparam int CFG_W  = 5;
	localparam int PRIO_W = 8;
	localparam logic [CFG_W-1:0] DONE_MAX = 5'd31;

	// Operation codes carried on the operation port.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

// File: rtl/core/ppsch_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ppsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read data is registered every cycle; a read of the address being written returns
	// the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: a load (operation 0) writes one task slot and gives
// no result. A tick (operation 1) keeps busy high through a scan, an update and a
// finish state, where the scan walks the smaller of process_count and MAX_TASKS slots:
// the task table sits in one RAM whose single read port is walked slot by slot through
// one shared compare unit that compares each registered read.
// The result word appears in the first cycle with busy low, for exactly one cycle with
// result_valid, and cannot be held off, so the receiver must capture it then.
// The table needs no clearing pass after reset.
// Depends on ppsch_pkg and ppsch_ram.
module preemptive_priority_scheduler
	import ppsch_pkg::*;
#(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Command channel.
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [$clog2(MAX_TASKS)-1:0] slot,
	input  logic [TIME_BITS-1:0]         arrival_time,
	input  logic [TIME_BITS-1:0]         burst_time,
	input  logic [PRIO_W-1:0]            priority_req,
	// Configuration channel.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_W-1:0]             cfg_data,
	// Result channel.
	output logic                         result_valid,
	output logic [TIME_BITS-1:0]         current_time,
	output logic [$clog2(MAX_TASKS)-1:0] running_slot,
	output logic                         idle,
	output logic                         new_slice,
	output logic                         finished,
	output logic [TIME_BITS-1:0]         completion_time,
	output logic [TIME_BITS-1:0]         turnaround_time,
	output logic [TIME_BITS-1:0]         waiting_time,
	output logic                         all_done
);

	localparam int SLOT_BITS = $clog2(MAX_TASKS);
	localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	typedef struct packed {
		logic [TIME_BITS-1:0] arrival;
		logic [TIME_BITS-1:0] burst;
		logic [TIME_BITS-1:0] remaining;
		logic [PRIO_W-1:0]    prio;
	} task_t;

	localparam int WORD_W = $bits(task_t);

	state_t                 state_q;
	logic [CFG_W-1:0]       process_count_q;
	logic [TIME_BITS-1:0]   clock_q;
	logic [CFG_W-1:0]       done_count_q;
	logic [CNT_BITS-1:0]    last_served_q;
	logic [MAX_TASKS-1:0]   loaded_q;

	logic [CNT_BITS-1:0]    idx_q;
	logic [CNT_BITS-1:0]    scan_len_q;
	logic                   rd_pend_s1;
	logic [SLOT_BITS-1:0]   idx_s1;
	logic                   found_q;
	logic [SLOT_BITS-1:0]   best_idx_q;
	task_t                  best_q;

	logic                   fin_q;
	logic                   newsl_q;
	logic [TIME_BITS-1:0]   tat_q;

	logic                   res_valid_q;
	logic [TIME_BITS-1:0]   res_time_q;
	logic [SLOT_BITS-1:0]   res_slot_q;
	logic                   res_idle_q;
	logic                   res_newsl_q;
	logic                   res_fin_q;
	logic [TIME_BITS-1:0]   res_ct_q;
	logic [TIME_BITS-1:0]   res_tat_q;
	logic [TIME_BITS-1:0]   res_wt_q;
	logic                   res_all_q;

	logic                   accept;
	logic                   load_we;
	logic                   upd_we;
	logic                   ram_we;
	logic [SLOT_BITS-1:0]   ram_waddr;
	task_t                  ram_wdata;
	task_t                  rd_word;
	logic [WORD_W-1:0]      rd_bits;
	logic                   eligible;
	logic                   take;
	logic [TIME_BITS-1:0]   next_time;
	logic [TIME_BITS-1:0]   rem_dec;
	logic [CNT_BITS-1:0]    scan_len;

	// Handshake decode.
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = start && !busy;
	assign load_we   = accept && (operation == OP_LOAD) && (int'(slot) < MAX_TASKS);
	assign upd_we    = (state_q == ST_UPDATE) && found_q;

	// Number of slots a tick looks at.
	assign scan_len = (int'(process_count_q) < MAX_TASKS) ?
		CNT_BITS'(process_count_q) : CNT_BITS'(MAX_TASKS);

	// One write port, shared between loads and the service update.
	always_comb begin
		rem_dec = best_q.remaining - TIME_BITS'(1);
		if (upd_we) begin
			ram_waddr           = best_idx_q;
			ram_wdata           = best_q;
			ram_wdata.remaining = rem_dec;
		end else begin
			ram_waddr           = slot;
			ram_wdata.arrival   = arrival_time;
			ram_wdata.burst     = burst_time;
			ram_wdata.remaining = burst_time;
			ram_wdata.prio      = priority_req;
		end
		ram_we = upd_we || load_we;
	end

	ppsch_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_TASKS)
	) u_task_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[SLOT_BITS-1:0]),
		.rdata (rd_bits)
	);

	assign rd_word = task_t'(rd_bits);

	// Shared compare unit: is the slot just read a better pick than the best so far.
	always_comb begin
		eligible = loaded_q[idx_s1] && (rd_word.remaining != '0) &&
			(rd_word.arrival <= clock_q);
		take = rd_pend_s1 && eligible && (!found_q || (rd_word.prio < best_q.prio) ||
			((rd_word.prio == best_q.prio) && (rd_word.arrival < best_q.arrival)));
		next_time = (clock_q < TIME_MAX) ? clock_q + TIME_BITS'(1) : TIME_MAX;
	end

	// Control state and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			process_count_q <= CFG_W'(16);
			clock_q         <= '0;
			done_count_q    <= '0;
			last_served_q   <= CNT_BITS'(MAX_TASKS);
			loaded_q        <= '0;
			idx_q           <= '0;
			scan_len_q      <= '0;
			rd_pend_s1      <= 1'b0;
			found_q         <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			res_valid_q <= (state_q == ST_FINISH);
			if (cfg_valid && cfg_ready) begin
				process_count_q <= cfg_data;
			end
			if (load_we) begin
				loaded_q[slot] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (operation == OP_TICK)) begin
						idx_q      <= '0;
						scan_len_q <= scan_len;
						rd_pend_s1 <= 1'b0;
						found_q    <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (take) begin
						found_q <= 1'b1;
					end
					if (idx_q < scan_len_q) begin
						rd_pend_s1 <= 1'b1;
						idx_q      <= idx_q + CNT_BITS'(1);
					end else begin
						// The last read is compared in this cycle.
						rd_pend_s1 <= 1'b0;
						state_q    <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					clock_q <= next_time;
					if (found_q) begin
						last_served_q <= CNT_BITS'(best_idx_q);
						if ((rem_dec == '0) && (done_count_q < DONE_MAX)) begin
							done_count_q <= done_count_q + CFG_W'(1);
						end
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Best-candidate and result payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			idx_s1 <= idx_q[SLOT_BITS-1:0];
			if (take) begin
				best_q     <= rd_word;
				best_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_UPDATE) begin
			fin_q   <= found_q && (rem_dec == '0);
			newsl_q <= found_q && (last_served_q != CNT_BITS'(best_idx_q));
			tat_q   <= (next_time >= best_q.arrival) ? next_time - best_q.arrival : '0;
		end
		if (state_q == ST_FINISH) begin
			res_time_q  <= clock_q;
			res_slot_q  <= found_q ? best_idx_q : '0;
			res_idle_q  <= !found_q;
			res_newsl_q <= newsl_q;
			res_fin_q   <= fin_q;
			res_ct_q    <= fin_q ? clock_q : '0;
			res_tat_q   <= fin_q ? tat_q : '0;
			res_wt_q    <= (fin_q && (tat_q >= best_q.burst)) ? tat_q - best_q.burst : '0;
			res_all_q   <= (done_count_q >= process_count_q);
		end
	end

	// Result ports.
	assign result_valid    = res_valid_q;
	assign current_time    = res_time_q;
	assign running_slot    = res_slot_q;
	assign idle            = res_idle_q;
	assign new_slice       = res_newsl_q;
	assign finished        = res_fin_q;
	assign completion_time = res_ct_q;
	assign turnaround_time = res_tat_q;
	assign waiting_time    = res_wt_q;
	assign all_done        = res_all_q;

endmodule

// File: rtl/core/ppsch_checker.sv
// Port-level checker for the preemptive priority scheduler, bound to the top level.
// Depends on ppsch_pkg and preemptive_priority_scheduler_macros.svh.
`include "preemptive_priority_scheduler_macros.svh"

module ppsch_checker
	import ppsch_pkg::*;
#(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         operation,
	input logic                         result_valid,
	input logic [$clog2(MAX_TASKS)-1:0] running_slot,
	input logic                         idle,
	input logic                         new_slice,
	input logic                         finished,
	input logic [TIME_BITS-1:0]         completion_time,
	input logic [TIME_BITS-1:0]         turnaround_time,
	input logic [TIME_BITS-1:0]         waiting_time
);

	// A result word is a single-cycle strobe.
	`PPSCH_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe held")

	// A tick word makes the block busy on the next cycle.
	`PPSCH_ASSERT_NEXT(a_tick_busy, start && !busy && (operation == OP_TICK), busy,
		"tick not started")

	// A load word finishes at once and gives no result.
	`PPSCH_ASSERT_NEXT(a_load_quiet, start && !busy && (operation == OP_LOAD),
		!busy && !result_valid, "load caused busy or result")

	// An idle tick serves nobody and reports no completion.
	`PPSCH_ASSERT_NOW(a_idle_word, result_valid && idle,
		!finished && !new_slice && (running_slot == '0) && (completion_time == '0),
		"idle result carries task data")

	// Times of an unfinished tick read as zero.
	`PPSCH_ASSERT_NOW(a_unfinished_zero, result_valid && !finished,
		(turnaround_time == '0) && (waiting_time == '0), "times set without completion")

endmodule

bind preemptive_priority_scheduler ppsch_checker #(
	.MAX_TASKS(MAX_TASKS),
	.TIME_BITS(TIME_BITS)
) u_ppsch_checker (.*);
